// ===== rtl/apmq_pkg.sv =====
// ----------------------------------------------------------------------------
// apmq_pkg
// Shared codes and fixed port field widths for the alarm priority mailbox.
// ----------------------------------------------------------------------------
package apmq_pkg;

    localparam int FIELD_BITS = 32;   // msg_payload / out_payload port width
    localparam int TOTAL_BITS = 5;    // total_count port width

    typedef logic [1:0] status_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NO_ROOM = 2'd1;
    localparam status_t ST_NO_MSG  = 2'd2;

    localparam logic OP_SEND     = 1'b0;
    localparam logic OP_RECV     = 1'b1;
    localparam logic KIND_NORMAL = 1'b0;
    localparam logic KIND_ALARM  = 1'b1;

    // result fields held in the output register
    typedef struct packed {
        status_t                 status;
        logic                    kind;
        logic                    from_ring;   // payload comes from ring read data
        logic [FIELD_BITS-1:0]   word;        // alarm word, or zero
        logic [TOTAL_BITS-1:0]   total;
        logic                    pending;
    } result_t;

endpackage

// ===== rtl/apmq_ring.sv =====
// ----------------------------------------------------------------------------
// apmq_ring
// Normal message storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module apmq_ring #(
    parameter  int DEPTH = 16,
    parameter  int WIDTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read so a stalled beat stays intact
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/alarm_priority_message_queue.sv =====
// ----------------------------------------------------------------------------
// alarm_priority_message_queue
// Mailbox with one priority alarm slot ahead of a bounded normal message ring.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)                         | tuser
//  s_      | in  | msg_payload[31:0]                             | opcode, msg_kind
//  m_      | out | status[1:0] out_payload[31:0] total_count[4:0]| out_kind
//          |     | alarm_pending                                 |
//
//  One beat per cycle unless stalled: a beat's decision and state update happen
//  at the edge it is accepted, its result is in the output register next cycle.
//  Ring read data comes from the memory's registered read port.
//  s_tready drops only while a result is held and m_tready is low.
//  aresetn (synchronous) empties the ring and the alarm slot; ring contents
//  are not cleared.
// ----------------------------------------------------------------------------
module alarm_priority_message_queue
    import apmq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // msg_payload[31:0]
    input  logic [1:0]  s_tuser,    // opcode[0], msg_kind[1]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // status[1:0], out_payload[33:2],
                                    // total_count[38:34], alarm_pending[39]
    output logic [0:0]  m_tuser     // out_kind[0]
);

    localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CW    = (PAYLOAD_BITS < FIELD_BITS) ? PAYLOAD_BITS : FIELD_BITS;

    // ---- state
    logic [PW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    alarm_full_reg, alarm_full_next;
    logic [PAYLOAD_BITS-1:0] alarm_word_reg, alarm_word_next;

    result_t                 res_reg, res_next;
    logic                    m_tvalid_reg;

    // ---- beat decode
    logic                    accept;
    logic                    opcode, kind;
    logic [PAYLOAD_BITS-1:0] in_word;
    logic                    ring_wr, ring_rd;
    logic [PAYLOAD_BITS-1:0] ring_rd_data;
    logic [SUM_W-1:0]        total_sum;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign opcode   = s_tuser[0];
    assign kind     = s_tuser[1];
    assign in_word  = PAYLOAD_BITS'(s_tdata[CW-1:0]);

    always_comb begin
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        count_next      = count_reg;
        alarm_full_next = alarm_full_reg;
        alarm_word_next = alarm_word_reg;
        ring_wr         = 1'b0;
        ring_rd         = 1'b0;
        res_next        = '0;
        res_next.status = ST_OK;

        if (accept) begin
            if (opcode == OP_SEND) begin
                if (kind == KIND_ALARM) begin
                    if (alarm_full_reg) begin
                        res_next.status = ST_NO_ROOM;
                    end else begin
                        alarm_full_next = 1'b1;
                        alarm_word_next = in_word;
                    end
                end else if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                    res_next.status = ST_NO_ROOM;
                end else begin
                    ring_wr     = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PW'(1);
                end
            end else if (alarm_full_reg) begin
                // alarm goes out ahead of the ring
                res_next.kind   = KIND_ALARM;
                res_next.word   = FIELD_BITS'(alarm_word_reg[CW-1:0]);
                alarm_full_next = 1'b0;
                alarm_word_next = '0;
            end else if (count_reg != '0) begin
                ring_rd            = 1'b1;
                res_next.from_ring = 1'b1;
                count_next         = count_reg - CNT_W'(1);
                rd_ptr_next        = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + PW'(1);
            end else begin
                res_next.status = ST_NO_MSG;
            end
        end

        total_sum        = SUM_W'(count_next) + SUM_W'(alarm_full_next);
        res_next.total   = TOTAL_BITS'(total_sum);
        res_next.pending = alarm_full_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
            alarm_full_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            count_reg      <= count_next;
            alarm_full_reg <= alarm_full_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        alarm_word_reg <= alarm_word_next;
        if (accept) begin
            res_reg <= res_next;
        end
    end

    apmq_ring #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (PAYLOAD_BITS)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr),
        .wr_addr (wr_ptr_reg),
        .wr_data (in_word),
        .rd_en   (ring_rd),
        .rd_addr (rd_ptr_reg),
        .rd_data (ring_rd_data)
    );

    logic [FIELD_BITS-1:0] out_word;

    assign out_word = res_reg.from_ring ? FIELD_BITS'(ring_rd_data[CW-1:0]) : res_reg.word;

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {res_reg.pending, res_reg.total, out_word, res_reg.status};
    assign m_tuser[0] = res_reg.kind;

endmodule
